FILE: rtl/core/accel_window_average_calibrate_assert.svh
// Assertion macros shared by the accelerometer window average and calibration block.
`ifndef ACCEL_WINDOW_AVERAGE_CALIBRATE_ASSERT_SVH
`define ACCEL_WINDOW_AVERAGE_CALIBRATE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define AWAC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("awac assertion failed");

// A condition seen at one edge implies a consequence at the next edge.
`define AWAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("awac assertion failed");

`else

`define AWAC_ASSERT_ALWAYS(lbl, prop)
`define AWAC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/awac_pkg.sv
// Types and constants shared by the accelerometer window average and calibration block.
`default_nettype none

package awac_pkg;

    // Register indexes of the configuration port.
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CAL_ROW_X     = 2'd0,
        CFG_CAL_ROW_Y     = 2'd1,
        CFG_CAL_ROW_Z     = 2'd2,
        CFG_GRAVITY_LEVEL = 2'd3
    } awac_cfg_idx_t;

    // Reset values: identity calibration and one g at 16384 counts.
    localparam logic [63:0] CAL_ROW_X_RESET   = 64'd4096;
    localparam logic [63:0] CAL_ROW_Y_RESET   = 64'd268435456;
    localparam logic [63:0] CAL_ROW_Z_RESET   = 64'd17592186044416;
    localparam logic [14:0] GRAVITY_RESET     = 15'd16384;

    // Load enables for the two pipeline stages that live in each calibration row.
    typedef struct packed {
        logic load_prod;
        logic load_out;
    } awac_stage_en_t;

endpackage

`default_nettype wire

FILE: rtl/core/awac_cal_row.sv
// One output row of the affine calibration: products, rounding, offset and saturation.
`default_nettype none

module awac_cal_row
    import awac_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 12
)
(
    input  logic                  clk,
    input  awac_stage_en_t        stage_en,
    input  logic [63:0]           row,
    input  logic signed [15:0]    vec_x,
    input  logic signed [15:0]    vec_y,
    input  logic signed [15:0]    vec_z,
    output logic signed [15:0]    cal
);

    localparam int ACC_W = 34;
    localparam int RES_W = ACC_W + 1;
    localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic signed [31:0]      prod_reg [3];
    logic [ACC_W-1:0]        acc_sum;
    logic signed [ACC_W-1:0] acc_shift;
    logic [RES_W-1:0]        res;
    logic signed [15:0]      cal_next;
    logic signed [15:0]      cal_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en.load_prod)
        begin
            prod_reg[0] <= 32'($signed(row[15:0]))  * 32'(vec_x);
            prod_reg[1] <= 32'($signed(row[31:16])) * 32'(vec_y);
            prod_reg[2] <= 32'($signed(row[47:32])) * 32'(vec_z);
        end
    end

    always_comb
    begin
        acc_sum = {{2{prod_reg[0][31]}}, prod_reg[0]}
                + {{2{prod_reg[1][31]}}, prod_reg[1]}
                + {{2{prod_reg[2][31]}}, prod_reg[2]}
                + ROUND;
        // Arithmetic shift gives the floor, so halves round up.
        acc_shift = $signed(acc_sum) >>> COEF_FRAC_BITS;
        res = {acc_shift[ACC_W-1], acc_shift}
            + {{(RES_W-16){row[63]}}, row[63:48]};
        if ((&res[RES_W-1:15]) || !(|res[RES_W-1:15]))
        begin
            cal_next = $signed(res[15:0]);
        end
        else if (res[RES_W-1])
        begin
            cal_next = 16'sh8000;
        end
        else
        begin
            cal_next = 16'sh7FFF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.load_out)
        begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

`default_nettype wire

FILE: rtl/core/accel_window_average_calibrate.sv
// Top level of the accelerometer window average, affine calibration and plausibility check.
//
// The block takes one signed three-axis sample per transaction and returns one calibrated
// result per transaction, in order. It accepts a new sample in every cycle unless in_stall
// is high; an accepted input reaches the output register through the pipeline stages (sum
// update, division by the window length and squares, calibration products and norm compare,
// rounding and saturation). A stall on the output backs up through the pipeline stage by
// stage, so in_stall rises only when all four stages hold a result. The sample window is a
// small register file that needs no clearing after reset: an old entry is subtracted from
// the running sums only once the window has been filled. Until the window holds WINDOW_LEN
// samples, the newest sample passes through and window_full is low. Configuration
// registers are written through cfg_we, cfg_index and cfg_data; the user writes them only
// while the block is idle, which the block itself does not enforce. A write takes effect at once.
`default_nettype none

`include "accel_window_average_calibrate_assert.svh"

module accel_window_average_calibrate
    import awac_pkg::*;
#(
    parameter int WINDOW_LEN     = 5,
    parameter int COEF_FRAC_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [15:0]     raw_x,
    input  logic signed [15:0]     raw_y,
    input  logic signed [15:0]     raw_z,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [15:0]     cal_x,
    output logic signed [15:0]     cal_y,
    output logic signed [15:0]     cal_z,
    output logic                   window_full,
    output logic                   plausible
);

    localparam int SUM_W       = 16 + $clog2(WINDOW_LEN);
    localparam int SLOT_W      = $clog2(WINDOW_LEN);
    localparam int FILL_W      = $clog2(WINDOW_LEN + 1);
    // Reciprocal multiply that is exact for every magnitude below 2^SUM_W.
    localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int PROD_W      = SUM_W + RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] RECIP =
        RECIP_SHIFT'(((1 << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [63:0] cal_row_reg [3];
    logic [14:0] gravity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_row_reg[0] <= CAL_ROW_X_RESET;
            cal_row_reg[1] <= CAL_ROW_Y_RESET;
            cal_row_reg[2] <= CAL_ROW_Z_RESET;
            gravity_reg    <= GRAVITY_RESET;
        end
        else if (cfg_we)
        begin
            case (awac_cfg_idx_t'(cfg_index))
                CFG_CAL_ROW_X:     cal_row_reg[0] <= cfg_data;
                CFG_CAL_ROW_Y:     cal_row_reg[1] <= cfg_data;
                CFG_CAL_ROW_Z:     cal_row_reg[2] <= cfg_data;
                CFG_GRAVITY_LEVEL: gravity_reg    <= cfg_data[14:0];
                default:           gravity_reg    <= gravity_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage loads when it is empty or when the
    // stage after it is loading too.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic ready1, ready2, ready3, ready4;
    logic accept;

    assign ready4   = !s4_valid_reg || !out_stall;
    assign ready3   = !s3_valid_reg || ready4;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign in_stall = !ready1;
    assign accept   = in_valid && ready1;

    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next;

    always_comb
    begin
        s1_valid_next = ready1 ? accept       : s1_valid_reg;
        s2_valid_next = ready2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = ready3 ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = ready4 ? s3_valid_reg : s4_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Sample window and running sums, updated at the accepting edge.
    // ------------------------------------------------------------------
    logic signed [15:0]      raw_in [3];
    logic [47:0]             window_mem [WINDOW_LEN];
    logic [47:0]             window_old_reg;
    logic [SLOT_W-1:0]       write_slot_reg, write_slot_next;
    logic [FILL_W-1:0]       fill_count_reg, fill_count_next;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [SUM_W-1:0] sum_next [3];
    logic                    full_now;
    logic                    full_after;

    assign raw_in[0] = raw_x;
    assign raw_in[1] = raw_y;
    assign raw_in[2] = raw_z;

    assign full_now   = (fill_count_reg == FILL_W'(WINDOW_LEN));
    assign full_after = full_now || (fill_count_reg == FILL_W'(WINDOW_LEN - 1));

    always_comb
    begin
        write_slot_next = write_slot_reg;
        fill_count_next = fill_count_reg;
        if (accept)
        begin
            if (write_slot_reg == SLOT_W'(WINDOW_LEN - 1))
            begin
                write_slot_next = '0;
            end
            else
            begin
                write_slot_next = write_slot_reg + SLOT_W'(1);
            end
            if (!full_now)
            begin
                fill_count_next = fill_count_reg + FILL_W'(1);
            end
        end
        // The entry being overwritten leaves the sum only once the window is full.
        for (int a = 0; a < 3; a++)
        begin
            sum_next[a] = sum_reg[a]
                        + {{(SUM_W-16){raw_in[a][15]}}, raw_in[a]}
                        - (full_now ? {{(SUM_W-16){window_old_reg[16*a+15]}},
                                       window_old_reg[16*a +: 16]}
                                    : SUM_W'(0));
        end
    end

    // The entry at the next write slot is fetched ahead, so it is ready when
    // the next sample arrives. The slot written now is never the one fetched.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_mem[write_slot_reg] <= {raw_z, raw_y, raw_x};
        end
        window_old_reg <= window_mem[write_slot_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            fill_count_reg <= '0;
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            fill_count_reg <= fill_count_next;
            if (accept)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    sum_reg[a] <= sum_next[a];
                end
            end
        end
    end

    // Stage 1: updated sums and the raw sample.
    logic signed [SUM_W-1:0] s1_sum_reg [3];
    logic signed [15:0]      s1_raw_reg [3];
    logic                    s1_full_reg;

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s1_sum_reg[a] <= sum_next[a];
                s1_raw_reg[a] <= raw_in[a];
            end
            s1_full_reg <= full_after;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: average by reciprocal multiply, truncated toward zero, and
    // the squares of the raw sample.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]   div_mag  [3];
    logic [PROD_W-1:0]  div_prod [3];
    logic [SUM_W-1:0]   div_quo  [3];
    logic [16:0]        div_avg  [3];
    logic signed [15:0] v_next   [3];
    logic [31:0]        sq_next  [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            div_mag[a]  = s1_sum_reg[a][SUM_W-1] ? SUM_W'(-s1_sum_reg[a])
                                                 : SUM_W'(s1_sum_reg[a]);
            div_prod[a] = PROD_W'(div_mag[a]) * PROD_W'(RECIP);
            div_quo[a]  = div_prod[a][PROD_W-1:RECIP_SHIFT];
            div_avg[a]  = s1_sum_reg[a][SUM_W-1] ? -div_quo[a][16:0] : div_quo[a][16:0];
            v_next[a]   = s1_full_reg ? $signed(div_avg[a][15:0]) : s1_raw_reg[a];
            sq_next[a]  = 32'(s1_raw_reg[a]) * 32'(s1_raw_reg[a]);
        end
    end

    logic signed [15:0] s2_v_reg  [3];
    logic [31:0]        s2_sq_reg [3];
    logic [29:0]        s2_g2_reg;
    logic               s2_full_reg;

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s2_v_reg[a]  <= v_next[a];
                s2_sq_reg[a] <= sq_next[a];
            end
            s2_g2_reg   <= 30'(gravity_reg) * 30'(gravity_reg);
            s2_full_reg <= s1_full_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared norm against a quarter and four times gravity
    // squared, bounds inclusive. The calibration rows form their products.
    // ------------------------------------------------------------------
    logic [33:0] norm2;
    logic        plaus_next;

    always_comb
    begin
        norm2 = {2'b00, s2_sq_reg[0]} + {2'b00, s2_sq_reg[1]} + {2'b00, s2_sq_reg[2]};
        plaus_next = ({norm2, 2'b00} >= {6'd0, s2_g2_reg})
                  && (norm2 <= {2'b00, s2_g2_reg, 2'b00});
    end

    logic s3_full_reg, s3_plaus_reg;
    logic s4_full_reg, s4_plaus_reg;

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            s3_full_reg  <= s2_full_reg;
            s3_plaus_reg <= plaus_next;
        end
        if (ready4)
        begin
            s4_full_reg  <= s3_full_reg;
            s4_plaus_reg <= s3_plaus_reg;
        end
    end

    // Stages 3 and 4 of the calibration live in the row units.
    awac_stage_en_t     row_en;
    logic signed [15:0] cal_out [3];

    assign row_en.load_prod = ready3;
    assign row_en.load_out  = ready4;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        awac_cal_row #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_row (
            .clk      (clk),
            .stage_en (row_en),
            .row      (cal_row_reg[r]),
            .vec_x    (s2_v_reg[0]),
            .vec_y    (s2_v_reg[1]),
            .vec_z    (s2_v_reg[2]),
            .cal      (cal_out[r])
        );
    end

    assign out_valid   = s4_valid_reg;
    assign cal_x       = cal_out[0];
    assign cal_y       = cal_out[1];
    assign cal_z       = cal_out[2];
    assign window_full = s4_full_reg;
    assign plausible   = s4_plaus_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The fill count saturates at the window length.
    `AWAC_ASSERT_ALWAYS(a_fill_bound, fill_count_reg <= FILL_W'(WINDOW_LEN))
    // While the window fills, the write slot follows the fill count.
    `AWAC_ASSERT_ALWAYS(a_slot_tracks_fill,
        full_now || (FILL_W'(write_slot_reg) == fill_count_reg))
    // An accepted sample is flagged full exactly when it completes or follows a full window.
    `AWAC_ASSERT_NEXT(a_full_flag, accept, s1_valid_reg && (s1_full_reg == full_now))
    // The input stalls only when every stage holds a result.
    `AWAC_ASSERT_ALWAYS(a_stall_only_when_full,
        !in_stall || (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg))

endmodule

`default_nettype wire
